/* rtl/core/fpp_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed polynomial predictor package
// Register map, order codes and shared types for the predictor core and its
// testbench.
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;

  typedef logic [1:0] order_t;
  typedef logic [1:0] warm_t;
  typedef logic [0:0] reg_idx_t;

  localparam reg_idx_t REG_ORDER = 1'b0;
  localparam reg_idx_t REG_MODE  = 1'b1;

  localparam order_t ORDER_NONE  = 2'd0;
  localparam order_t ORDER_ONE   = 2'd1;
  localparam order_t ORDER_TWO   = 2'd2;
  localparam order_t ORDER_THREE = 2'd3;

  localparam order_t ORDER_RESET = ORDER_ONE;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam warm_t WARM_ZERO = 2'd0;
  localparam warm_t WARM_ONE  = 2'd1;
  localparam warm_t WARM_FULL = 2'd3;

endpackage

/* rtl/core/fixed_polynomial_predictor_core.sv */
// ----------------------------------------------------------------------------
// Fixed polynomial predictor core
// Fixed-order (0 to 3) linear predictor for audio: turns samples into
// residuals in encode mode and residuals back into samples in decode mode.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                               | Direction
//  ---------+---------------------------------------+----------
//  input    | in_valid, in_stall, data_in, run_start | into core
//  output   | out_valid, out_stall, data_out        | out of core
//  config   | psel, penable, pwrite, paddr, pwdata,  | APB slave
//           | prdata, pready                        |
//
// One transaction is taken every cycle while in_stall is low; each result passes
// through the input register and then the result register.
// The prediction and the history update happen in the same cycle from the input
// register, so every transaction sees the history its predecessor left.
// A stalled result holds the result register and, once the input register is
// also full, raises in_stall. Reset clears the history, the warm-up count,
// both valid flags and the configuration registers.
module fixed_polynomial_predictor_core #(
  parameter int DATA_WIDTH = 21
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fpp_pkg::ADDR_W-1:0]          paddr,
  input  logic [fpp_pkg::PDATA_W-1:0]         pwdata,
  output logic [fpp_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [DATA_WIDTH-1:0]        data_in,
  input  logic                                run_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [DATA_WIDTH-1:0]        data_out
);

  fpp_pkg::order_t       predictor_order;
  logic                  decode_mode;
  logic                  cfg_write;

  logic                  in_full;
  logic [DATA_WIDTH-1:0] in_data;
  logic                  in_run_start;
  logic                  in_move;
  logic                  out_load;

  logic [DATA_WIDTH-1:0] hist0;
  logic [DATA_WIDTH-1:0] hist1;
  logic [DATA_WIDTH-1:0] hist2;
  fpp_pkg::warm_t        warm_count;

  logic [DATA_WIDTH-1:0] x1;
  logic [DATA_WIDTH-1:0] x2;
  logic [DATA_WIDTH-1:0] x3;
  fpp_pkg::warm_t        warm_eff;
  logic [DATA_WIDTH-1:0] prediction;
  logic                  warming;
  logic [DATA_WIDTH-1:0] result_next;
  logic [DATA_WIDTH-1:0] sample_next;
  fpp_pkg::warm_t        warm_count_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_order <= fpp_pkg::ORDER_RESET;
      decode_mode     <= fpp_pkg::MODE_ENCODE;
    end else if (cfg_write) begin
      if (paddr[2] == fpp_pkg::REG_ORDER) begin
        predictor_order <= pwdata[1:0];
      end else begin
        decode_mode <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == fpp_pkg::REG_ORDER) begin
      prdata[1:0] = predictor_order;
    end else begin
      prdata[0] = decode_mode;
    end
  end

  assign out_load = !out_valid || !out_stall;
  assign in_move  = in_full && out_load;
  assign in_stall = in_full && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data      <= data_in;
      in_run_start <= run_start;
    end
  end

  // A run start sees a cleared history and warm-up count.
  assign x1       = in_run_start ? '0 : hist0;
  assign x2       = in_run_start ? '0 : hist1;
  assign x3       = in_run_start ? '0 : hist2;
  assign warm_eff = in_run_start ? fpp_pkg::WARM_ZERO : warm_count;

  always_comb begin
    case (predictor_order)
      fpp_pkg::ORDER_NONE:  prediction = '0;
      fpp_pkg::ORDER_ONE:   prediction = x1;
      fpp_pkg::ORDER_TWO:   prediction = (x1 << 1) - x2;
      fpp_pkg::ORDER_THREE: prediction = ((x1 << 1) + x1) - ((x2 << 1) + x2) + x3;
      default:              prediction = '0;
    endcase
  end

  assign warming = warm_eff < predictor_order;

  always_comb begin
    if (warming) begin
      result_next = in_data;
      sample_next = in_data;
    end else if (decode_mode == fpp_pkg::MODE_DECODE) begin
      result_next = prediction + in_data;
      sample_next = result_next;
    end else begin
      result_next = in_data - prediction;
      sample_next = in_data;
    end
  end

  assign warm_count_next = (warm_eff == fpp_pkg::WARM_FULL) ? fpp_pkg::WARM_FULL
                                                            : warm_eff + fpp_pkg::WARM_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist0      <= '0;
      hist1      <= '0;
      hist2      <= '0;
      warm_count <= fpp_pkg::WARM_ZERO;
    end else if (in_move) begin
      hist0      <= sample_next;
      hist1      <= x1;
      hist2      <= x2;
      warm_count <= warm_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move) begin
      data_out <= result_next;
    end
  end

endmodule

/* rtl/core/fpp_checker.sv */
// ----------------------------------------------------------------------------
// Fixed polynomial predictor checker
// Port-level assertions on the predictor core, attached by a bind statement.
// ----------------------------------------------------------------------------
module fpp_checker #(
  parameter int DATA_WIDTH = 21
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [DATA_WIDTH-1:0]  data_out
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_out))
    else $error("result changed while stalled");

  // The input side only stalls when the result register is full and held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A result after an empty output comes from an earlier input transaction.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a matching input transaction");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind fixed_polynomial_predictor_core fpp_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_fpp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .data_out  (data_out)
);

/* test/fixed_polynomial_predictor_core_test.sv */
// ----------------------------------------------------------------------------
// Fixed polynomial predictor core testbench
// Programs predictor order and direction over the APB port, streams samples
// or residuals through the core with random bursts and output stalls, and
// compares every result against a cycle-free model of the predictor.
// ----------------------------------------------------------------------------
module fixed_polynomial_predictor_core_test;

  localparam int DW           = 21;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1900;

  typedef logic [DW-1:0] word_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC, STALL_COIN} stall_style_t;
  typedef enum {SHAPE_NOISE, SHAPE_SMOOTH, SHAPE_EXTREME, SHAPE_SMALL} shape_t;

  localparam word_t WORD_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DW-1){1'b0}}};

  class predictor_scoreboard;
    fpp_pkg::order_t order;
    logic            mode;
    word_t           history [3];
    fpp_pkg::warm_t  warm;
    word_t           pending [$];
    int              errors;
    int              accepted;
    int              checked;

    function new();
      order    = fpp_pkg::ORDER_RESET;
      mode     = fpp_pkg::MODE_ENCODE;
      warm     = fpp_pkg::WARM_ZERO;
      foreach (history[i]) history[i] = '0;
      errors   = 0;
      accepted = 0;
      checked  = 0;
    endfunction

    function word_t prediction();
      word_t x1, x2, x3;
      x1 = history[0];
      x2 = history[1];
      x3 = history[2];
      case (order)
        fpp_pkg::ORDER_ONE:   return x1;
        fpp_pkg::ORDER_TWO:   return (x1 << 1) - x2;
        fpp_pkg::ORDER_THREE: return x1 + x1 + x1 - x2 - x2 - x2 + x3;
        default:              return '0;
      endcase
    endfunction

    function void note_input(word_t d, logic start);
      word_t result, sample;
      if (start) begin
        foreach (history[i]) history[i] = '0;
        warm = fpp_pkg::WARM_ZERO;
      end
      if (warm < order) begin
        result = d;
        sample = d;
      end else if (mode == fpp_pkg::MODE_DECODE) begin
        result = prediction() + d;
        sample = result;
      end else begin
        result = d - prediction();
        sample = d;
      end
      history[2] = history[1];
      history[1] = history[0];
      history[0] = sample;
      if (warm != fpp_pkg::WARM_FULL) warm = warm + 1'b1;
      pending = {pending, result};
      accepted++;
    endfunction

    function void check_result(word_t got);
      word_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: data_out with nothing outstanding, expected none, actual %0d",
                 $time, $signed(got));
      end else begin
        want = pending.pop_front();
        checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: data_out mismatch, expected %0d, actual %0d",
                   $time, $signed(want), $signed(got));
        end
      end
    endfunction

    function void flush_check();
      if (pending.size() != 0) begin
        errors++;
        $display("%0t: %0d results never arrived, expected %0d first, actual none",
                 $time, pending.size(), $signed(pending[0]));
      end
    endfunction
  endclass

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [fpp_pkg::ADDR_W-1:0]   paddr     = '0;
  logic [fpp_pkg::PDATA_W-1:0]  pwdata    = '0;
  logic [fpp_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic signed [DW-1:0]         data_in   = '0;
  logic                         run_start = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [DW-1:0]         data_out;

  predictor_scoreboard fpp_sb = new();

  int           burst_left  = 0;
  int           idle_cycles = 0;
  int           stall_left  = 0;
  stall_style_t stall_style = STALL_NONE;
  logic [7:0]   settings_seen = '0;

  fixed_polynomial_predictor_core #(.DATA_WIDTH(DW)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) fpp_sb.note_input(data_in, run_start);
      if (out_valid && !out_stall) fpp_sb.check_result(data_out);
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 4));
      stall_left  = $urandom_range(16, 200);
    end
    stall_left--;
    case (stall_style)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= stall_left[2];
      default:        out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // The watchdog only counts cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic set_reg(fpp_pkg::reg_idx_t idx, logic [fpp_pkg::PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == fpp_pkg::REG_ORDER) fpp_sb.order = fpp_pkg::order_t'(value);
    else fpp_sb.mode = value[0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      fpp_sb.errors++;
      $display("%0t: register %0d read back wrong, expected %0d, actual %0d",
               $time, idx, value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(word_t d, logic start);
    int gap;
    in_valid  <= 1'b1;
    data_in   <= d;
    run_start <= start;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(0, 15);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fpp_sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int     sent;
    int     phase_left;
    int     run_len;
    int     k;
    int     base;
    int     slope;
    int     curve;
    shape_t shape;
    logic   fresh;
    logic   start;
    word_t  value;
    word_t  extremes [5];

    extremes = '{WORD_MAX, WORD_MIN, '0, '1, word_t'(1)};
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings first, then warm-up and wrap-around at both extremes.
    send_item(WORD_MAX, 1'b1);
    send_item(WORD_MIN, 1'b0);
    send_item('0, 1'b0);
    drain();
    set_reg(fpp_pkg::REG_ORDER, fpp_pkg::ORDER_THREE);
    send_item(WORD_MAX, 1'b1);
    send_item(WORD_MIN, 1'b0);
    send_item(WORD_MAX, 1'b0);
    send_item(WORD_MIN, 1'b0);
    send_item('0, 1'b0);
    drain();
    set_reg(fpp_pkg::REG_MODE, fpp_pkg::MODE_DECODE);
    send_item(WORD_MAX, 1'b1);
    send_item(WORD_MAX, 1'b0);
    send_item(WORD_MAX, 1'b0);
    send_item(WORD_MIN, 1'b0);
    send_item(WORD_MIN, 1'b0);
    drain();
    // The order changes in the middle of a run, then a restart lands mid-stream.
    set_reg(fpp_pkg::REG_ORDER, fpp_pkg::ORDER_TWO);
    send_item(word_t'(1), 1'b0);
    send_item('1, 1'b0);
    send_item(WORD_MAX, 1'b1);
    send_item(word_t'(1), 1'b0);
    drain();
    set_reg(fpp_pkg::REG_ORDER, fpp_pkg::ORDER_NONE);
    set_reg(fpp_pkg::REG_MODE, fpp_pkg::MODE_ENCODE);
    send_item(WORD_MIN, 1'b1);
    send_item(WORD_MAX, 1'b0);
    settings_seen[{fpp_pkg::ORDER_ONE, fpp_pkg::MODE_ENCODE}]   = 1'b1;
    settings_seen[{fpp_pkg::ORDER_THREE, fpp_pkg::MODE_ENCODE}] = 1'b1;
    settings_seen[{fpp_pkg::ORDER_THREE, fpp_pkg::MODE_DECODE}] = 1'b1;
    settings_seen[{fpp_pkg::ORDER_TWO, fpp_pkg::MODE_DECODE}]   = 1'b1;
    settings_seen[{fpp_pkg::ORDER_NONE, fpp_pkg::MODE_ENCODE}]  = 1'b1;

    while (sent < RANDOM_ITEMS) begin
      drain();
      set_reg(fpp_pkg::REG_ORDER, $urandom_range(0, 3));
      set_reg(fpp_pkg::REG_MODE, $urandom_range(0, 1));
      settings_seen[{fpp_sb.order, fpp_sb.mode}] = 1'b1;
      phase_left = $urandom_range(40, 160);
      fresh      = ($urandom_range(0, 9) < 7);
      while (phase_left > 0 && sent < RANDOM_ITEMS) begin
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 60);
        shape   = shape_t'($urandom_range(0, 3));
        base    = $urandom;
        slope   = $urandom_range(0, 2000) - 1000;
        curve   = $urandom_range(0, 20) - 10;
        for (k = 0; k < run_len && phase_left > 0 && sent < RANDOM_ITEMS; k++) begin
          start = (k == 0) ? fresh : ($urandom_range(0, 99) == 0);
          case (shape)
            SHAPE_SMOOTH:  value = word_t'(base + slope * k + curve * k * k);
            SHAPE_EXTREME: value = extremes[$urandom_range(0, 4)];
            SHAPE_SMALL:   value = word_t'($urandom_range(0, 64) - 32);
            default:       value = word_t'($urandom);
          endcase
          send_item(value, start);
          sent++;
          phase_left--;
        end
        fresh = ($urandom_range(0, 9) != 0);
      end
    end

    drain();
    fpp_sb.flush_check();
    $display("Streamed %0d input transactions and checked %0d results.",
             fpp_sb.accepted, fpp_sb.checked);
    $display("Covered %0d of 8 order and direction settings, with warm-up, restarts and wrap.",
             $countones(settings_seen));
    if (fpp_sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
